FILE: design/gia_pkg.sv
package gia_pkg;

  localparam int unsigned DEF_CAPACITY = 128;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned COUNT_OUT_W  = 8;

  // Half-open intervals [s1,e1) and [s2,e2) share a point.
  function automatic logic intervals_meet(
    input logic signed [COORD_W-1:0] s1,
    input logic signed [COORD_W-1:0] e1,
    input logic signed [COORD_W-1:0] s2,
    input logic signed [COORD_W-1:0] e2
  );
    intervals_meet = (s1 < e2) && (s2 < e1);
  endfunction

endpackage

FILE: design/greedy_interval_admission_unit.sv
// Channel   Handshake                 Payload
// command   start in, busy out        interval_start, interval_end, last_in_set
// result    done out (one cycle)      accepted, store_full, accepted_count
//
// An item with N intervals kept in the current set is checked by one store
// read per kept entry through the single read port, then decided and, if
// accepted, written in the finish state before the next command is taken.
// The registered result strobe appears in the cycle after the decision; the
// next command may be accepted in that same cycle. Reset (rst, synchronous)
// empties the set; stored entries are not cleared. Results cannot be stalled.
module greedy_interval_admission_unit
  import gia_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] interval_start,
  input  logic signed [COORD_W-1:0] interval_end,
  input  logic                      last_in_set,
  output logic                      done,
  output logic                      accepted,
  output logic                      store_full,
  output logic [COUNT_OUT_W-1:0]    accepted_count
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = 2 * COORD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t                     state;
  logic [CW-1:0]              cnt;
  logic [AW-1:0]              idx;
  logic signed [COORD_W-1:0]  cur_start;
  logic signed [COORD_W-1:0]  cur_end;
  logic                       cur_last;
  logic                       hit;
  logic                       cmp_valid;

  logic                       rd_en;
  logic [DW-1:0]              rd_data;
  logic                       wr_en;
  logic                       meet;
  logic                       final_hit;
  logic                       room;
  logic                       scan_last;

  assign busy      = (state != ST_IDLE);
  assign rd_en     = (state == ST_SCAN);
  assign meet      = cmp_valid && intervals_meet(rd_data[DW-1:COORD_W],
                                                 rd_data[COORD_W-1:0],
                                                 cur_start, cur_end);
  assign final_hit = hit || meet;
  assign room      = (cnt < CW'(CAPACITY));
  assign wr_en     = (state == ST_FINISH) && !final_hit && room;
  assign scan_last = (CW'(idx) == cnt - CW'(1));

  // Writes land at entry cnt only in the finish state, after the scan ends; the
  // next scan starts only after a pass through idle, so no read sees a stale entry.
  gia_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (DW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt[AW-1:0]),
    .wr_data ({cur_start, cur_end}),
    .rd_en   (rd_en),
    .rd_addr (idx),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      idx       <= '0;
      hit       <= 1'b0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmp_valid) begin
        hit <= hit || meet;
      end
      unique case (state)
        ST_IDLE: begin
          cmp_valid <= 1'b0;
          if (start) begin
            cur_start <= interval_start;
            cur_end   <= interval_end;
            cur_last  <= last_in_set;
            idx       <= '0;
            hit       <= 1'b0;
            state     <= (cnt == '0) ? ST_FINISH : ST_SCAN;
          end
        end
        ST_SCAN: begin
          cmp_valid <= 1'b1;
          idx       <= idx + AW'(1);
          if (scan_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          cmp_valid  <= 1'b0;
          done       <= 1'b1;
          accepted   <= !final_hit && room;
          store_full <= !final_hit && !room;
          if (!final_hit && room) begin
            accepted_count <= COUNT_OUT_W'(cnt + CW'(1));
          end else begin
            accepted_count <= COUNT_OUT_W'(cnt);
          end
          // Drop the set after the last beat's result is formed.
          if (cur_last) begin
            cnt <= '0;
          end else if (!final_hit && room) begin
            cnt <= cnt + CW'(1);
          end
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/gia_store.sv
module gia_store #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7,
  parameter int unsigned DW    = 64
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
